### sv/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

   localparam int MAX_BASE_DEFAULT   = 16;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 8;
   localparam int BASE_W      = 5;
   localparam int ALPHA_W     = 64;
   localparam int ALPHA_SLOTS = 16;

   localparam int STORE_DEPTH = 32;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = STORE_AW + 1;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
   localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;

   typedef enum logic [2:0] {
      REG_SRC_ALPHA_LO = 3'd0,
      REG_SRC_ALPHA_HI = 3'd1,
      REG_SRC_BASE     = 3'd2,
      REG_TGT_ALPHA_LO = 3'd3,
      REG_TGT_ALPHA_HI = 3'd4,
      REG_TGT_BASE     = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_ACC  = 2'd1,
      ST_DIV  = 2'd2,
      ST_EMIT = 2'd3
   } state_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] source_alphabet_low;
      logic [ALPHA_W-1:0] source_alphabet_high;
      logic [BASE_W-1:0]  source_base;
      logic [ALPHA_W-1:0] target_alphabet_low;
      logic [ALPHA_W-1:0] target_alphabet_high;
      logic [BASE_W-1:0]  target_base;
   } cfg_type;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b,
                                                    input int max_base);
      logic [BASE_W-1:0] r;
      r = b;
      if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (int'(b) > max_base) begin
         r = BASE_W'(max_base);
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] lo,
                                                    input logic [ALPHA_W-1:0] hi,
                                                    input logic [DIGIT_W-1:0] d);
      logic [ALPHA_W-1:0] word;
      word = d[3] ? hi : lo;
      return word[{d[2:0], 3'b000} +: CHAR_W];
   endfunction

   // highest matching slot below the base wins; no match keeps dflt
   function automatic logic [DIGIT_W-1:0] match_digit(input logic [ALPHA_W-1:0] lo,
                                                      input logic [ALPHA_W-1:0] hi,
                                                      input logic [BASE_W-1:0] base,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [DIGIT_W-1:0] dflt);
      logic [DIGIT_W-1:0] d;
      d = dflt;
      for (int j = 0; j < ALPHA_SLOTS; j++) begin
         if ((BASE_W'(j) < base) && (alpha_char(lo, hi, DIGIT_W'(j)) == ch)) begin
            d = DIGIT_W'(j);
         end
      end
      return d;
   endfunction

endpackage

`default_nettype wire

### sv/rsc_csr_regs.sv
`default_nettype none

module rsc_csr_regs (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [rsc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [rsc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [rsc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output rsc_pkg::cfg_type                      cfg
);

   // field order: src lo, src hi, src base, tgt lo, tgt hi, tgt base
   localparam rsc_pkg::cfg_type CFG_RESET = {{(2*rsc_pkg::ALPHA_W){1'b0}}, rsc_pkg::BASE_RESET,
                                             {(2*rsc_pkg::ALPHA_W){1'b0}}, rsc_pkg::BASE_RESET};

   rsc_pkg::cfg_type      cfg_ff;
   rsc_pkg::cfg_type      cfg_in;
   rsc_pkg::reg_index_type idx;
   logic                  wr_en;

   // 64-bit registers sit on 8-byte strides
   assign idx    = rsc_pkg::reg_index_type'(paddr[5:3]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            rsc_pkg::REG_SRC_ALPHA_LO: cfg_in.source_alphabet_low  = pwdata;
            rsc_pkg::REG_SRC_ALPHA_HI: cfg_in.source_alphabet_high = pwdata;
            rsc_pkg::REG_SRC_BASE:     cfg_in.source_base = pwdata[rsc_pkg::BASE_W-1:0];
            rsc_pkg::REG_TGT_ALPHA_LO: cfg_in.target_alphabet_low  = pwdata;
            rsc_pkg::REG_TGT_ALPHA_HI: cfg_in.target_alphabet_high = pwdata;
            rsc_pkg::REG_TGT_BASE:     cfg_in.target_base = pwdata[rsc_pkg::BASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         rsc_pkg::REG_SRC_ALPHA_LO: prdata = cfg_ff.source_alphabet_low;
         rsc_pkg::REG_SRC_ALPHA_HI: prdata = cfg_ff.source_alphabet_high;
         rsc_pkg::REG_SRC_BASE:     prdata = rsc_pkg::CSR_DATA_W'(cfg_ff.source_base);
         rsc_pkg::REG_TGT_ALPHA_LO: prdata = cfg_ff.target_alphabet_low;
         rsc_pkg::REG_TGT_ALPHA_HI: prdata = cfg_ff.target_alphabet_high;
         rsc_pkg::REG_TGT_BASE:     prdata = rsc_pkg::CSR_DATA_W'(cfg_ff.target_base);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### sv/rsc_div_unit.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. done pulses the cycle after the
// last step; quotient and remainder then hold until the next start.
module rsc_div_unit #(
   parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [VALUE_BITS-1:0]       dividend,
   input  wire logic [rsc_pkg::BASE_W-1:0]  divisor,
   output logic      [VALUE_BITS-1:0]       quotient,
   output rsc_pkg::div_status_type          status
);

   localparam int CNT_W = $clog2(VALUE_BITS);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]         q_ff, q_in;
   logic [rsc_pkg::DIGIT_W-1:0]   rem_ff, rem_in;
   logic [rsc_pkg::BASE_W-1:0]    div_ff, div_in;

   logic [rsc_pkg::BASE_W-1:0]    trial;
   logic [rsc_pkg::BASE_W-1:0]    diff;
   logic                          ge;

   // remainder stays below the divisor (<= 16), so 4 bits hold it
   assign trial = {rem_ff, q_ff[VALUE_BITS-1]};
   assign ge    = trial >= div_ff;
   assign diff  = trial - div_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[VALUE_BITS-2:0], ge};
         rem_in = ge ? diff[rsc_pkg::DIGIT_W-1:0] : trial[rsc_pkg::DIGIT_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient         = q_ff;
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

`default_nettype wire

### sv/radix_string_converter_core.sv
`default_nettype none

// Channel  Dir  Ports                               Beat
// req      in   req_valid/req_stall, req_in_char,   one source character
//               req_in_last
// rsp      out  rsp_valid/rsp_stall, rsp_out_char,  one target digit character
//               rsp_out_last
// csr      in   psel/penable/pwrite/paddr/pwdata,   64-bit register write/read
//               prdata, pready
//
// A source character is latched, then matched and multiply-added into the accumulator.
// The last character then runs the bit-serial divider once per target digit, and the
// digits are emitted one per cycle while rsp is not stalled.
// req_stall is high whenever the sequencer is not idle; rsp has an output register.
// Reset is synchronous; the digit store needs no clearing.
module radix_string_converter_core #(
   parameter int MAX_BASE   = rsc_pkg::MAX_BASE_DEFAULT,
   parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [rsc_pkg::CHAR_W-1:0]      req_in_char,
   input  wire logic                            req_in_last,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [rsc_pkg::CHAR_W-1:0]      rsp_out_char,
   output logic                                 rsp_out_last,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rsc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [rsc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [rsc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);

   localparam int DW = rsc_pkg::DIGIT_W;
   localparam int CW = rsc_pkg::COUNT_W;

   rsc_pkg::cfg_type        cfg;
   rsc_pkg::div_status_type div_status;
   logic [VALUE_BITS-1:0]   div_quotient;
   logic                    div_start;
   logic [VALUE_BITS-1:0]   div_dividend;

   rsc_pkg::state_type      state_ff, state_in;
   logic [rsc_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                    last_ff, last_in;
   logic [VALUE_BITS-1:0]   acc_ff, acc_in;
   logic [DW-1:0]           prev_ff, prev_in;
   logic [CW-1:0]           digit_cnt_ff, digit_cnt_in;
   logic [CW-1:0]           emit_idx_ff, emit_idx_in;
   logic [DW-1:0]           store_ff [rsc_pkg::STORE_DEPTH];
   logic [DW-1:0]           store_rd_ff;
   logic [rsc_pkg::STORE_AW-1:0] rd_addr;
   logic                    store_we;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [rsc_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [rsc_pkg::BASE_W-1:0] src_base;
   logic [rsc_pkg::BASE_W-1:0] tgt_base;
   logic [DW-1:0]           digit;
   logic [VALUE_BITS+rsc_pkg::BASE_W-1:0] product;
   logic [VALUE_BITS-1:0]   acc_sum;
   logic [CW-1:0]           cnt_next;
   logic [CW-1:0]           emit_rd;
   logic                    out_free;

   rsc_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rsc_div_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (tgt_base),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign src_base = rsc_pkg::clamp_base(cfg.source_base, MAX_BASE);
   assign tgt_base = rsc_pkg::clamp_base(cfg.target_base, MAX_BASE);
   assign digit    = rsc_pkg::match_digit(cfg.source_alphabet_low, cfg.source_alphabet_high,
                                          src_base, char_ff, prev_ff);
   assign product  = acc_ff * src_base;
   assign acc_sum  = product[VALUE_BITS-1:0] + VALUE_BITS'(digit);
   assign cnt_next = digit_cnt_ff + CW'(1);
   assign emit_rd  = emit_idx_ff - CW'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // entry needed by the next emit cycle
   assign rd_addr  = rsc_pkg::STORE_AW'(emit_idx_in - CW'(1));

   always_comb begin
      state_in     = state_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      digit_cnt_in = digit_cnt_ff;
      emit_idx_in  = emit_idx_ff;
      store_we     = 1'b0;
      div_start    = 1'b0;
      div_dividend = acc_sum;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         rsc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               char_in  = req_in_char;
               last_in  = req_in_last;
               state_in = rsc_pkg::ST_ACC;
            end
         end
         rsc_pkg::ST_ACC: begin
            acc_in  = acc_sum;
            prev_in = digit;
            if (last_ff) begin
               div_start    = 1'b1;
               digit_cnt_in = '0;
               state_in     = rsc_pkg::ST_DIV;
            end else begin
               state_in = rsc_pkg::ST_IDLE;
            end
         end
         rsc_pkg::ST_DIV: begin
            if (div_status.done) begin
               store_we     = 1'b1;
               digit_cnt_in = cnt_next;
               // stop on a zero quotient or a full store
               if ((div_quotient == '0) || (cnt_next == CW'(rsc_pkg::STORE_DEPTH))) begin
                  emit_idx_in = cnt_next;
                  state_in    = rsc_pkg::ST_EMIT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_quotient;
               end
            end
         end
         rsc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rsc_pkg::alpha_char(cfg.target_alphabet_low,
                                 cfg.target_alphabet_high, store_rd_ff);
               rsp_last_in  = emit_idx_ff == CW'(1);
               emit_idx_in  = emit_rd;
               if (emit_idx_ff == CW'(1)) begin
                  acc_in   = '0;
                  prev_in  = '0;
                  state_in = rsc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = rsc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsc_pkg::ST_IDLE;
         acc_ff       <= '0;
         prev_ff      <= '0;
         digit_cnt_ff <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         prev_ff      <= prev_in;
         digit_cnt_ff <= digit_cnt_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff     <= char_in;
      last_ff     <= last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[digit_cnt_ff[rsc_pkg::STORE_AW-1:0]] <= div_status.remainder;
      end
   end

   // the top digit is written on the edge into emit, so it is forwarded
   always_ff @(posedge clock) begin
      if (store_we && (digit_cnt_ff[rsc_pkg::STORE_AW-1:0] == rd_addr)) begin
         store_rd_ff <= div_status.remainder;
      end else begin
         store_rd_ff <= store_ff[rd_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_out_last = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_accept_to_acc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == rsc_pkg::ST_ACC))
      else $error("accepted beat did not enter accumulate");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsc_pkg::ST_EMIT) |-> (emit_idx_ff != '0))
      else $error("emit with no digits left");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == rsc_pkg::ST_DIV))
      else $error("divider finished outside the divide phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (digit_cnt_ff <= CW'(rsc_pkg::STORE_DEPTH)) && (emit_idx_ff <= digit_cnt_ff))
      else $error("digit count out of range");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] HEX_LO = 64'h3736353433323130;  // "01234567"
   localparam logic [63:0] HEX_HI = 64'h4645444342413938;  // "89ABCDEF"
   localparam logic [63:0] DEC_HI = 64'h0000000000003938;  // "89"
   localparam logic [63:0] BIN_LO = 64'h0000000000003130;  // "01"
   localparam int NUM_PHASES      = 8;
   localparam int CHARS_PER_PHASE = 40;
   localparam int SETTLE_CYCLES   = 8;

   typedef struct {
      logic [rsc_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } digit_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   wire logic             req_stall;
   logic [rsc_pkg::CHAR_W-1:0] req_in_char = '0;
   logic                  req_in_last = 1'b0;
   wire logic             rsp_valid;
   logic                  rsp_stall = 1'b0;
   wire logic [rsc_pkg::CHAR_W-1:0] rsp_out_char;
   wire logic             rsp_out_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [rsc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [rsc_pkg::CSR_DATA_W-1:0] pwdata = '0;
   wire logic [rsc_pkg::CSR_DATA_W-1:0] prdata;
   wire logic             pready;

   rsc_pkg::cfg_type    cfg_shadow;
   logic [31:0]         running_value = '0;
   logic [rsc_pkg::DIGIT_W-1:0] carry_digit = '0;
   digit_beat_type      expected_digits[$];
   int                  error_count = 0;
   bit                  no_idle = 1'b0;

   radix_string_converter_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_char  (req_in_char),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      cfg_shadow = '0;
      cfg_shadow.source_base = rsc_pkg::BASE_RESET;
      cfg_shadow.target_base = rsc_pkg::BASE_RESET;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [rsc_pkg::CHAR_W-1:0] alphabet_byte(input logic [63:0] lo,
                                                                input logic [63:0] hi,
                                                                input int unsigned d);
      logic [63:0] word;
      word = (d < 8) ? lo : hi;
      return word[(d % 8) * 8 +: rsc_pkg::CHAR_W];
   endfunction

   function automatic int unsigned effective_base(input logic [rsc_pkg::BASE_W-1:0] b);
      if (b < 2) return 2;
      if (int'(b) > rsc_pkg::MAX_BASE_DEFAULT) return rsc_pkg::MAX_BASE_DEFAULT;
      return int'(b);
   endfunction

   function automatic void convert_char(input logic [rsc_pkg::CHAR_W-1:0] ch,
                                        input logic is_last);
      int unsigned                 src_b;
      int unsigned                 tgt_b;
      int                          n;
      logic [rsc_pkg::DIGIT_W-1:0] d;
      logic [31:0]                 v;
      logic [rsc_pkg::DIGIT_W-1:0] rems[32];
      digit_beat_type              beat;
      src_b = effective_base(cfg_shadow.source_base);
      tgt_b = effective_base(cfg_shadow.target_base);
      d = carry_digit;
      for (int unsigned j = 0; j < src_b; j++) begin
         if (alphabet_byte(cfg_shadow.source_alphabet_low,
                           cfg_shadow.source_alphabet_high, j) == ch) begin
            d = rsc_pkg::DIGIT_W'(j);
         end
      end
      carry_digit = d;
      running_value = 32'(64'(running_value) * src_b + d);
      if (!is_last) return;
      v = running_value;
      n = 0;
      do begin
         rems[n] = rsc_pkg::DIGIT_W'(v % tgt_b);
         v = v / tgt_b;
         n++;
      end while (v != 0 && n < 32);
      for (int k = n - 1; k >= 0; k--) begin
         beat.ch   = alphabet_byte(cfg_shadow.target_alphabet_low,
                                   cfg_shadow.target_alphabet_high, rems[k]);
         beat.last = (k == 0);
         expected_digits.push_back(beat);
      end
      running_value = '0;
      carry_digit = '0;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         convert_char(req_in_char, req_in_last);
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : digit_check
      digit_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected digit beat char=0x%02h last=%b",
                                      rsp_out_char, rsp_out_last));
         end else begin
            want = expected_digits.pop_front();
            if (rsp_out_char !== want.ch) begin
               report_mismatch($sformatf("out_char got 0x%02h exp 0x%02h",
                                         rsp_out_char, want.ch));
            end
            if (rsp_out_last !== want.last) begin
               report_mismatch($sformatf("out_last got %b exp %b",
                                         rsp_out_last, want.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   function automatic int pick_idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side backpressure; hold keeps a long stall going without re-driving
   initial begin : rsp_backpressure
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            hold = pick_idle_len() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // valid stays high after the beat is taken; the next call or release_req moves it
   task automatic send_char(input logic [rsc_pkg::CHAR_W-1:0] ch, input logic is_last);
      int gap;
      gap = (!no_idle && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= ch;
      req_in_last <= is_last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      release_req();
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic csr_write(input rsc_pkg::reg_index_type idx,
                            input logic [rsc_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         rsc_pkg::REG_SRC_ALPHA_LO: cfg_shadow.source_alphabet_low  = val;
         rsc_pkg::REG_SRC_ALPHA_HI: cfg_shadow.source_alphabet_high = val;
         rsc_pkg::REG_SRC_BASE:     cfg_shadow.source_base = val[rsc_pkg::BASE_W-1:0];
         rsc_pkg::REG_TGT_ALPHA_LO: cfg_shadow.target_alphabet_low  = val;
         rsc_pkg::REG_TGT_ALPHA_HI: cfg_shadow.target_alphabet_high = val;
         rsc_pkg::REG_TGT_BASE:     cfg_shadow.target_base = val[rsc_pkg::BASE_W-1:0];
         default: ;
      endcase
   endtask

   // junk in the upper bits; only the low five bits of a base register count
   function automatic logic [63:0] base_word(input logic [rsc_pkg::BASE_W-1:0] b);
      return {$urandom, 27'($urandom), b};
   endfunction

   task automatic load_config(input logic [63:0] src_lo, input logic [63:0] src_hi,
                              input logic [63:0] src_base, input logic [63:0] tgt_lo,
                              input logic [63:0] tgt_hi, input logic [63:0] tgt_base);
      wait_drained();
      csr_write(rsc_pkg::REG_SRC_ALPHA_LO, src_lo);
      csr_write(rsc_pkg::REG_SRC_ALPHA_HI, src_hi);
      csr_write(rsc_pkg::REG_SRC_BASE, src_base);
      csr_write(rsc_pkg::REG_TGT_ALPHA_LO, tgt_lo);
      csr_write(rsc_pkg::REG_TGT_ALPHA_HI, tgt_hi);
      csr_write(rsc_pkg::REG_TGT_BASE, tgt_base);
   endtask

   // ---------------------------------------------------------------- tests

   // zeroed alphabets: every slot matches 0x00, so slot 9 wins; 'A' is unmatched
   task automatic test_reset_defaults();
      send_char(8'h00, 1'b0);
      send_char(8'h41, 1'b1);
   endtask

   task automatic test_hex_to_decimal();
      load_config(HEX_LO, HEX_HI, base_word(5'd16), HEX_LO, DEC_HI, base_word(5'd10));
      send_string("FFFFFFFF");
      send_string("0");
      send_string("1zz");   // unmatched chars repeat the previous digit
      send_string("z5");    // unmatched first char counts as zero
   endtask

   task automatic test_base_limits();
      // base 1 behaves as 2, so 'F' is outside the alphabet; 31 behaves as 16
      load_config(HEX_LO, HEX_HI, base_word(5'd1), HEX_LO, HEX_HI, base_word(5'd31));
      send_string("1F1");
      // 17 clamps to 16, 0 clamps to 2: a full 32-digit binary result
      load_config(HEX_LO, HEX_HI, base_word(5'd17), BIN_LO, 64'h0, base_word(5'd0));
      send_string("F0000000");
   endtask

   task automatic send_random_number(input int unsigned len);
      int unsigned                sb;
      logic [rsc_pkg::CHAR_W-1:0] ch;
      sb = effective_base(cfg_shadow.source_base);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            ch = alphabet_byte(cfg_shadow.source_alphabet_low,
                               cfg_shadow.source_alphabet_high, $urandom_range(0, sb - 1));
         end else begin
            ch = 8'($urandom);
         end
         send_char(ch, i == len - 1);
      end
   endtask

   function automatic logic [rsc_pkg::BASE_W-1:0] pick_base();
      if ($urandom_range(0, 9) == 0) return rsc_pkg::BASE_W'($urandom_range(0, 31));
      return rsc_pkg::BASE_W'($urandom_range(2, 16));
   endfunction

   function automatic logic [63:0] pick_alphabet();
      case ($urandom_range(0, 11))
         0:       return 64'h0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_random_conversions();
      logic [rsc_pkg::BASE_W-1:0] sb;
      logic [rsc_pkg::BASE_W-1:0] tb;
      int                         count;
      int unsigned                len;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       begin sb = 5'd16; tb = 5'd2;  end
            1:       begin sb = 5'd2;  tb = 5'd16; end
            default: begin sb = pick_base(); tb = pick_base(); end
         endcase
         load_config(pick_alphabet(), pick_alphabet(), base_word(sb),
                     pick_alphabet(), pick_alphabet(), base_word(tb));
         no_idle = (phase == 3 || phase == 6);
         count = 0;
         while (count < CHARS_PER_PHASE) begin
            case ($urandom_range(0, 9))
               0, 1:    len = 1;
               2:       len = $urandom_range(9, 12);   // wraps the running value
               default: len = $urandom_range(2, 8);
            endcase
            send_random_number(len);
            count += len;
            if ($urandom_range(0, 29) == 0) wait_drained();
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_hex_to_decimal();
      test_base_limits();
      test_random_conversions();
      wait_drained();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("TIMEOUT: %0d digit beats still outstanding", expected_digits.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
sv/rsc_pkg.sv
sv/rsc_csr_regs.sv
sv/rsc_div_unit.sv
sv/radix_string_converter_core.sv
tb/tb_top.sv
